// File: hw/rtl/kfc_pkg.sv
// shared constants and types for the k-mer frequency counter
package kfc_pkg;

  localparam int unsigned MAX_K_DEF = 8;
  localparam int unsigned KSIZE_W   = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned QUERY_W   = 16;
  localparam int unsigned COUNT_W   = 32;

  typedef enum logic {
    REQ_BASE  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

  localparam logic [1:0] NT_A = 2'd0;
  localparam logic [1:0] NT_C = 2'd1;
  localparam logic [1:0] NT_G = 2'd2;
  localparam logic [1:0] NT_T = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } nt_t;

endpackage

// File: hw/rtl/kfc_ram.sv
// generic single write port ram with registered read
module kfc_ram #(
  parameter int unsigned          DataW = 32,
  parameter longint unsigned      Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/kmer_frequency_counter_core.sv
// k-mer frequency counter top level: base window, count table and query path
//
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o | req_type, base_char, read_end, query_code
// out     | output    | out_valid_o / out_stall_i | query_echo, kmer_count
// cfg     | input     | cfg_we_i                | cfg_wdata_i (kmer_size)
//
// one request per cycle while in_stall_o is low; a query result is registered in stage one, then in the result register
// the count table read-modify-write reads on acceptance and writes back from stage one, with one-deep forwarding
// after reset a clearing pass writes zero to all 4^MAX_K table entries, one per
// cycle, while in_stall_o stays high
// a query held by a stalled output register stalls the input
module kmer_frequency_counter_core
  import kfc_pkg::*;
#(
  parameter int unsigned MAX_K = MAX_K_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [KSIZE_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_req_type_i,
  input  logic [CHAR_W-1:0]  in_base_char_i,
  input  logic               in_read_end_i,
  input  logic [QUERY_W-1:0] in_query_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [QUERY_W-1:0] out_query_echo_o,
  output logic [COUNT_W-1:0] out_kmer_count_o
);

  localparam int unsigned          AddrW = 2 * MAX_K;
  localparam longint unsigned      Depth = longint'(1) << AddrW;
  localparam int unsigned          KW    = $clog2(MAX_K + 1);

  function automatic nt_t decode_nt(input logic [CHAR_W-1:0] c);
    nt_t r;
    r.valid = 1'b1;
    unique case (c) inside
      CHAR_A_UP, CHAR_A_LO: r.code = NT_A;
      CHAR_C_UP, CHAR_C_LO: r.code = NT_C;
      CHAR_G_UP, CHAR_G_LO: r.code = NT_G;
      CHAR_T_UP, CHAR_T_LO: r.code = NT_T;
      default: begin
        r.valid = 1'b0;
        r.code  = NT_A;
      end
    endcase
    return r;
  endfunction

  logic [KSIZE_W-1:0] ksize_q;
  logic [AddrW-1:0]   win_q, win_d, win_shift;
  logic [KW-1:0]      run_q, run_d, run_inc, k_eff;
  logic [AddrW-1:0]   kmask, ins;
  nt_t                nt;
  logic               count_hit;

  logic               in_accept;
  logic               is_query;

  logic               clr_q;
  logic [AddrW-1:0]   clr_addr_q;

  logic               s1_valid_q, s1_query_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [QUERY_W-1:0] s1_echo_q;
  logic               s1_hold;
  logic [COUNT_W-1:0] s1_data, s1_sum;

  logic               fwd_valid_q;
  logic [AddrW-1:0]   fwd_addr_q;
  logic [COUNT_W-1:0] fwd_data_q;

  logic               out_valid_q;
  logic [QUERY_W-1:0] out_echo_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_load;

  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  // handshake
  assign s1_hold    = s1_valid_q & s1_query_q & out_valid_q & out_stall_i;
  assign in_stall_o = clr_q | s1_hold;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign is_query   = (in_req_type_i == REQ_QUERY);

  // window update
  always_comb begin
    if (ksize_q == '0) begin
      k_eff = KW'(1);
    end else if (int'(ksize_q) > int'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(ksize_q);
    end
  end

  assign nt = decode_nt(in_base_char_i);

  always_comb begin
    kmask = '0;
    ins   = '0;
    for (int i = 0; i < int'(MAX_K); i++) begin
      kmask[2*i +: 2] = (KW'(i) < k_eff) ? 2'b11 : 2'b00;
      if (KW'(i) == k_eff - KW'(1)) begin
        ins[2*i +: 2] = nt.code;
      end
    end
  end

  assign win_shift = ((win_q >> 2) | ins) & kmask;
  assign run_inc   = (run_q < k_eff) ? run_q + KW'(1) : run_q;
  assign count_hit = nt.valid & (run_inc == k_eff);

  always_comb begin
    win_d = win_q;
    run_d = run_q;
    if (cfg_we_i) begin
      win_d = '0;
      run_d = '0;
    end else if (in_accept && !is_query) begin
      if (!nt.valid || in_read_end_i) begin
        win_d = '0;
        run_d = '0;
      end else begin
        win_d = win_shift;
        run_d = run_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q <= KSIZE_W'(1);
      win_q   <= '0;
      run_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        ksize_q <= cfg_wdata_i;
      end
      win_q <= win_d;
      run_q <= run_d;
    end
  end

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == '1) begin
        clr_q <= 1'b0;
      end
    end
  end

  // table access
  assign ram_re    = in_accept;
  assign ram_raddr = is_query ? AddrW'(in_query_code_i) : win_shift;

  assign s1_data = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : ram_rdata;
  assign s1_sum  = s1_data + COUNT_W'(1);

  assign ram_we    = clr_q | (s1_valid_q & ~s1_query_q);
  assign ram_waddr = clr_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_q ? '0 : s1_sum;

  kfc_ram #(
    .DataW (COUNT_W),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid_q  <= in_accept & (is_query | count_hit);
      fwd_valid_q <= s1_valid_q & ~s1_query_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!s1_hold) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= s1_sum;
      if (in_accept) begin
        s1_query_q <= is_query;
        s1_addr_q  <= ram_raddr;
        s1_echo_q  <= in_query_code_i;
      end
    end
  end

  // result register
  assign out_load = s1_valid_q & s1_query_q & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_echo_q  <= s1_echo_q;
      out_count_q <= s1_data;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_query_echo_o = out_echo_q;
  assign out_kmer_count_o = out_count_q;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_accept)
    else $error("request accepted during table clear");

  a_clear_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_valid_q)
    else $error("table update collides with clearing pass");

  a_inc_never_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_query_q) |-> !s1_hold)
    else $error("count update held in stage one");

  a_inc_forwarded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_query_q) |=> fwd_valid_q)
    else $error("count update lost from forwarding register");
`endif

endmodule

// File: sim/kmer_frequency_counter_core_test.sv
// testbench for the k-mer frequency counter core: directed and random requests, self-checking
`timescale 1ns / 100ps

module kmer_frequency_counter_core_test;
  import kfc_pkg::*;

  localparam int unsigned TALLY_DEPTH  = 1 << (2 * MAX_K_DEF);
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned QUIET_LIMIT  = 300000;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned POOL_DEPTH   = 16;
  localparam logic [CHAR_W-1:0] CHAR_N_UP = 8'h4E;

  typedef struct {
    logic [QUERY_W-1:0] echo;
    logic [COUNT_W-1:0] count;
  } count_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [KSIZE_W-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               in_req_type_i;
  logic [CHAR_W-1:0]  in_base_char_i;
  logic               in_read_end_i;
  logic [QUERY_W-1:0] in_query_code_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [QUERY_W-1:0] out_query_echo_o;
  logic [COUNT_W-1:0] out_kmer_count_o;

  // predictor state
  bit   [COUNT_W-1:0] kmer_tally [TALLY_DEPTH];
  logic [QUERY_W-1:0] window_m;
  int unsigned        run_m;
  logic [KSIZE_W-1:0] kmer_size_m;
  logic [QUERY_W-1:0] recent_kmers [$];
  count_result_t      pending_counts [$];

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int quiet_cycles;
  int n_errors;

  kmer_frequency_counter_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_req_type_i    (in_req_type_i),
    .in_base_char_i   (in_base_char_i),
    .in_read_end_i    (in_read_end_i),
    .in_query_code_i  (in_query_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_query_echo_o (out_query_echo_o),
    .out_kmer_count_o (out_kmer_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
    if (n_errors < 50) begin
      $display("mismatch in %s: expected %h, got %h at %0t", what, exp_val, got_val, $time);
    end
    n_errors++;
  endtask

  function automatic void track_base(logic [CHAR_W-1:0] ch, logic last);
    int unsigned k;
    nt_t         nt;
    logic [31:0] win;
    if (kmer_size_m == 0) begin
      k = 1;
    end else if (kmer_size_m > MAX_K_DEF) begin
      k = MAX_K_DEF;
    end else begin
      k = 32'(kmer_size_m);
    end
    case (ch)
      CHAR_A_UP, CHAR_A_LO: nt = '{valid: 1'b1, code: NT_A};
      CHAR_C_UP, CHAR_C_LO: nt = '{valid: 1'b1, code: NT_C};
      CHAR_G_UP, CHAR_G_LO: nt = '{valid: 1'b1, code: NT_G};
      CHAR_T_UP, CHAR_T_LO: nt = '{valid: 1'b1, code: NT_T};
      default:              nt = '{valid: 1'b0, code: NT_A};
    endcase
    if (!nt.valid) begin
      window_m = '0;
      run_m    = 0;
    end else begin
      win = ((32'(window_m) >> 2) | (32'(nt.code) << (2 * (k - 1))))
            & ((32'd1 << (2 * k)) - 32'd1);
      window_m = win[QUERY_W-1:0];
      if (run_m < k) run_m++;
      if (run_m >= k) begin
        kmer_tally[window_m] = kmer_tally[window_m] + 32'd1;
        recent_kmers.push_back(window_m);
        if (recent_kmers.size() > POOL_DEPTH) void'(recent_kmers.pop_front());
      end
    end
    if (last) begin
      window_m = '0;
      run_m    = 0;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] acgt_char(logic [1:0] code);
    logic lower;
    lower = 1'($urandom_range(1));
    case (code)
      NT_A:    return lower ? CHAR_A_LO : CHAR_A_UP;
      NT_C:    return lower ? CHAR_C_LO : CHAR_C_UP;
      NT_G:    return lower ? CHAR_G_LO : CHAR_G_UP;
      default: return lower ? CHAR_T_LO : CHAR_T_UP;
    endcase
  endfunction

  function automatic logic [QUERY_W-1:0] choose_query();
    if (recent_kmers.size() != 0 && $urandom_range(99) < 60) begin
      return recent_kmers[$urandom_range(recent_kmers.size() - 1)];
    end
    return QUERY_W'($urandom_range(65535));
  endfunction

  // one request; the predictor is updated at the edge that takes it
  task automatic send_item(req_type_e req, logic [CHAR_W-1:0] ch, logic last,
                           logic [QUERY_W-1:0] code);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_req_type_i   <= req;
    in_base_char_i  <= ch;
    in_read_end_i   <= last;
    in_query_code_i <= code;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (req == REQ_QUERY) begin
      pending_counts.push_back('{echo: code, count: kmer_tally[code]});
    end else begin
      track_base(ch, last);
    end
  endtask

  task automatic send_base(logic [CHAR_W-1:0] ch, logic last);
    send_item(REQ_BASE, ch, last, QUERY_W'($urandom_range(65535)));
  endtask

  task automatic send_query(logic [QUERY_W-1:0] code);
    send_item(REQ_QUERY, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)), code);
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_counts.size() != 0 || in_stall_o !== 1'b0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_kmer_size(logic [KSIZE_W-1:0] value);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    kmer_size_m = value;
    window_m    = '0;
    run_m       = 0;
  endtask

  task automatic random_traffic(int n_items);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0) begin
            send_base(CHAR_W'($urandom_range(255)), i == len - 1);
          end else begin
            send_base(acgt_char(2'($urandom_range(3))), i == len - 1);
          end
        end
        sent += len;
      end else if (pick < 90) begin
        send_query(choose_query());
        sent++;
      end else begin
        send_base(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic test_reset_state();
    send_query(16'h0000);
    send_query(16'hFFFF);
  endtask

  task automatic test_single_base();
    write_kmer_size(4'd1);
    send_base(CHAR_A_UP, 1'b0);
    send_base(CHAR_C_LO, 1'b0);
    send_base(CHAR_G_UP, 1'b0);
    send_base(CHAR_T_LO, 1'b1);
    for (int i = 0; i < 4; i++) send_query(QUERY_W'(i));
  endtask

  task automatic test_long_kmer();
    write_kmer_size(4'd8);
    for (int i = 0; i < 8; i++) send_base(acgt_char(2'(i)), i == 7);
    send_query(recent_kmers[$]);
  endtask

  task automatic test_restart_chars();
    write_kmer_size(4'd2);
    send_base(CHAR_G_UP, 1'b0);
    send_base(CHAR_N_UP, 1'b1);
    send_base(CHAR_A_UP, 1'b0);
    send_base(CHAR_N_UP, 1'b0);
    send_base(CHAR_T_UP, 1'b0);
    send_base(CHAR_G_LO, 1'b0);
    send_query(recent_kmers[$]);
    // window restarts on a kmer_size write
    write_kmer_size(4'd2);
    send_base(CHAR_C_UP, 1'b1);
    send_query(recent_kmers[$]);
  endtask

  task automatic test_backpressure();
    settle_block();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_cycles     = HOLD_LEN;
    for (int i = 0; i < 48; i++) begin
      if (i % 2 == 0) begin
        send_query(choose_query());
      end else begin
        send_base(acgt_char(2'($urandom_range(3))), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_phases();
    int                 idle_mix [4][2];
    logic [KSIZE_W-1:0] k_plan [8];
    idle_mix = '{'{0, 0}, '{59, 0}, '{0, 59}, '{32, 32}};
    k_plan   = '{4'd0, 4'd15, 4'd2, 4'd4, 4'd6, 4'd9, 4'd7, 4'd3};
    for (int p = 0; p < 8; p++) begin
      write_kmer_size(k_plan[p]);
      sender_idle_pct = idle_mix[p / 2][0];
      recv_stall_pct  = idle_mix[p / 2][1];
      random_traffic(135);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    count_result_t exp_res;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, 32'(out_query_echo_o));
      end else begin
        exp_res = pending_counts.pop_front();
        if (out_query_echo_o !== exp_res.echo) begin
          report_mismatch("query_echo", 32'(exp_res.echo), 32'(out_query_echo_o));
        end
        if (out_kmer_count_o !== exp_res.count) begin
          report_mismatch("kmer_count", exp_res.count, out_kmer_count_o);
        end
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    in_req_type_i   = REQ_BASE;
    in_base_char_i  = '0;
    in_read_end_i   = 1'b0;
    in_query_code_i = '0;
    out_stall_i     = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 0;
    quiet_cycles    = 0;
    n_errors        = 0;
    window_m        = '0;
    run_m           = 0;
    kmer_size_m     = 4'd1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_single_base();
    test_long_kmer();
    test_restart_chars();
    test_backpressure();
    test_random_phases();
    settle_block();

    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
